FILE: hdl/tftpw_pkg.sv
// shared types and constants of the tftp write receiver
`timescale 1ns / 1ps

package tftpw_pkg;

  localparam int BLOCK_BYTES    = 512;
  localparam int FINISH_REPEATS = 6;
  localparam int MAX_RESULTS    = 6;

  // results per flash event, clamped to 1..MAX_RESULTS
  localparam int REPEAT_N = (FINISH_REPEATS > MAX_RESULTS) ? MAX_RESULTS :
                            (FINISH_REPEATS < 1) ? 1 : FINISH_REPEATS;
  localparam int CNT_W    = $clog2(MAX_RESULTS + 1);

  localparam logic [31:0] BLOCK_BYTES_W = 32'(BLOCK_BYTES);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // tftp opcodes
  localparam logic [15:0] OP_RRQ   = 16'd1;
  localparam logic [15:0] OP_WRQ   = 16'd2;
  localparam logic [15:0] OP_DATA  = 16'd3;
  localparam logic [15:0] OP_ACK   = 16'd4;
  localparam logic [15:0] OP_ERROR = 16'd5;

  // request kinds
  localparam logic [1:0] REQ_PACKET  = 2'd0;
  localparam logic [1:0] REQ_TIMEOUT = 2'd1;
  localparam logic [1:0] REQ_FLASH   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_OUR_PORT   = 2'd0;
  localparam logic [1:0] CFG_FINISH_OPC = 2'd1;
  localparam logic [1:0] CFG_LOAD_BASE  = 2'd2;

  localparam logic [15:0] RESET_OUR_PORT   = 16'd69;
  localparam logic [15:0] RESET_FINISH_OPC = 16'd6;

  typedef enum logic [3:0] {
    PH_WAIT   = 4'b0001,
    PH_WRQ    = 4'b0010,
    PH_DATA   = 4'b0100,
    PH_FINISH = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] dest_port;
    logic [15:0] src_port;
    logic [15:0] udp_len;
    logic [15:0] opcode;
    logic [15:0] block_num;
    logic        write_ok;
  } in_t;

  typedef struct packed {
    logic        reply_valid;
    logic [15:0] reply_opcode;
    logic [15:0] reply_word;
    logic [15:0] reply_port;
    logic        store_valid;
    logic [31:0] store_addr;
    logic [15:0] store_len;
    logic        transfer_done;
    logic [31:0] total_size;
    logic        restart;
    logic        last;
  } out_t;

  // decoded command passed from front to back
  typedef struct packed {
    logic             reply_valid;
    logic [15:0]      reply_opcode;
    logic [15:0]      reply_word;
    logic [15:0]      reply_port;
    logic             store_valid;
    logic [31:0]      offs;
    logic [15:0]      store_len;
    logic             transfer_done;
    logic             restart;
    logic [CNT_W-1:0] repeats;
  } cmd_t;

  typedef struct packed {
    logic [15:0] our_port;
    logic [15:0] finish_opcode;
    logic [31:0] load_base;
  } cfg_t;

endpackage

FILE: hdl/tftpw_front.sv
// front end: classifies each request, updates transfer state, builds a command
`timescale 1ns / 1ps

module tftpw_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  tftpw_pkg::in_t      in_data,
  input  tftpw_pkg::cfg_t     cfg,
  output logic                push,
  output tftpw_pkg::cmd_t     push_cmd
);
  import tftpw_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] partner_r, partner_nxt;
  logic [15:0] cur_blk_r, cur_blk_nxt;
  logic [15:0] prev_blk_r, prev_blk_nxt;
  logic        armed_r, armed_nxt;
  logic        flag_r, flag_nxt;

  logic        port_ok;
  logic [15:0] pay;
  logic [31:0] blk_m1;
  logic [31:0] offs;
  logic [15:0] prev_eff;
  phase_t      phase_eff;
  logic [15:0] partner_eff;
  logic        has_cmd;
  cmd_t        cmd;

  function automatic cmd_t reply_cmd(phase_t ph, logic [15:0] blk, logic flag,
                                     logic [15:0] port, logic [15:0] fin_opc);
    cmd_t c;
    c = '0;
    c.reply_valid = 1'b1;
    c.reply_port  = port;
    c.repeats     = CNT_W'(1);
    unique case (ph)
      PH_WAIT: begin
        c.reply_opcode = OP_DATA;
        c.reply_word   = blk;
      end
      PH_FINISH: begin
        c.reply_opcode = fin_opc;
        c.reply_word   = {15'd0, flag};
      end
      default: begin
        c.reply_opcode = OP_ACK;
        c.reply_word   = blk;
      end
    endcase
    return c;
  endfunction

  assign port_ok  = (in_data.dest_port == cfg.our_port) &&
                    ((phase_r == PH_WAIT) || (in_data.src_port == partner_r)) &&
                    (in_data.udp_len >= 16'd2);
  assign pay      = in_data.udp_len - 16'd4;
  assign blk_m1   = {16'd0, in_data.block_num} - 32'd1;
  // wraps modulo 2^32 for block zero
  assign offs     = blk_m1 * BLOCK_BYTES_W;

  always_comb begin
    phase_nxt    = phase_r;
    partner_nxt  = partner_r;
    cur_blk_nxt  = cur_blk_r;
    prev_blk_nxt = prev_blk_r;
    armed_nxt    = armed_r;
    flag_nxt     = flag_r;
    has_cmd      = 1'b0;
    cmd          = '0;
    phase_eff    = phase_r;
    partner_eff  = partner_r;
    prev_eff     = prev_blk_r;

    unique case (in_data.req_type)
      REQ_PACKET: begin
        if (port_ok) begin
          unique case (in_data.opcode)
            OP_RRQ: begin
              partner_nxt = in_data.src_port;
              cur_blk_nxt = 16'd1;
              phase_nxt   = PH_WAIT;
              has_cmd     = 1'b1;
              cmd         = reply_cmd(PH_WAIT, 16'd1, flag_r, in_data.src_port,
                                      cfg.finish_opcode);
            end
            OP_WRQ: begin
              partner_nxt = in_data.src_port;
              cur_blk_nxt = 16'd0;
              phase_nxt   = PH_WRQ;
              has_cmd     = 1'b1;
              cmd         = reply_cmd(PH_WRQ, 16'd0, flag_r, in_data.src_port,
                                      cfg.finish_opcode);
            end
            OP_DATA: begin
              if (in_data.udp_len >= 16'd4) begin
                cur_blk_nxt = in_data.block_num;
                if (phase_r == PH_WRQ) begin
                  phase_eff    = PH_DATA;
                  partner_eff  = in_data.src_port;
                  prev_eff     = 16'd0;
                  phase_nxt    = PH_DATA;
                  partner_nxt  = in_data.src_port;
                  prev_blk_nxt = 16'd0;
                end
                if (phase_r == PH_WRQ && in_data.block_num != 16'd1) begin
                  // first block must be block 1
                  phase_nxt   = PH_WAIT;
                  cur_blk_nxt = 16'd0;
                  armed_nxt   = 1'b0;
                  has_cmd     = 1'b1;
                  cmd.restart = 1'b1;
                  cmd.repeats = CNT_W'(1);
                end else if (in_data.block_num != prev_eff) begin
                  prev_blk_nxt      = in_data.block_num;
                  armed_nxt         = 1'b1;
                  has_cmd           = 1'b1;
                  cmd               = reply_cmd(phase_eff, in_data.block_num, flag_r,
                                                partner_eff, cfg.finish_opcode);
                  cmd.store_valid   = 1'b1;
                  cmd.offs          = offs;
                  cmd.store_len     = pay;
                  if ({16'd0, pay} < BLOCK_BYTES_W) begin
                    phase_nxt         = PH_FINISH;
                    cmd.transfer_done = 1'b1;
                  end
                end
              end
            end
            OP_ERROR: begin
              phase_nxt   = PH_WAIT;
              cur_blk_nxt = 16'd0;
              armed_nxt   = 1'b0;
              has_cmd     = 1'b1;
              cmd.restart = 1'b1;
              cmd.repeats = CNT_W'(1);
            end
            default: ;
          endcase
        end
      end
      REQ_TIMEOUT: begin
        if (armed_r) begin
          has_cmd = 1'b1;
          cmd     = reply_cmd(phase_r, cur_blk_r, flag_r, partner_r, cfg.finish_opcode);
        end
      end
      REQ_FLASH: begin
        if (phase_r == PH_FINISH) begin
          flag_nxt    = in_data.write_ok;
          has_cmd     = 1'b1;
          cmd         = reply_cmd(PH_FINISH, cur_blk_r, in_data.write_ok, partner_r,
                                  cfg.finish_opcode);
          cmd.repeats = CNT_W'(REPEAT_N);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_WAIT;
      partner_r  <= 16'd0;
      cur_blk_r  <= 16'd0;
      prev_blk_r <= 16'd0;
      armed_r    <= 1'b0;
      flag_r     <= 1'b0;
    end else if (in_fire) begin
      phase_r    <= phase_nxt;
      partner_r  <= partner_nxt;
      cur_blk_r  <= cur_blk_nxt;
      prev_blk_r <= prev_blk_nxt;
      armed_r    <= armed_nxt;
      flag_r     <= flag_nxt;
    end
  end

  assign push     = in_fire && has_cmd;
  assign push_cmd = cmd;

endmodule

FILE: hdl/tftpw_queue.sv
// short command queue between front and back
`timescale 1ns / 1ps

module tftpw_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tftpw_pkg::cmd_t   push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output tftpw_pkg::cmd_t   head_cmd
);
  import tftpw_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_pop;

  assign full       = (count_r == (QPTR_W + 1)'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

FILE: hdl/tftpw_back.sv
// back end: expands commands into result items and holds the output register
`timescale 1ns / 1ps

module tftpw_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  tftpw_pkg::cmd_t   head_cmd,
  output logic              pop,
  input  logic [31:0]       load_base,
  output logic              out_valid,
  input  logic              out_stall,
  output tftpw_pkg::out_t   out_data
);
  import tftpw_pkg::*;

  logic             out_valid_r;
  out_t             out_r, out_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             can_load;
  logic             load;
  logic             is_last;

  assign can_load = !out_valid_r || !out_stall;
  assign load     = can_load && head_valid;
  assign is_last  = (cnt_r == head_cmd.repeats - 1'b1);
  assign pop      = load && is_last;

  always_comb begin
    out_nxt               = '0;
    out_nxt.reply_valid   = head_cmd.reply_valid;
    out_nxt.reply_opcode  = head_cmd.reply_opcode;
    out_nxt.reply_word    = head_cmd.reply_word;
    out_nxt.reply_port    = head_cmd.reply_port;
    out_nxt.store_valid   = head_cmd.store_valid;
    out_nxt.store_len     = head_cmd.store_len;
    out_nxt.transfer_done = head_cmd.transfer_done;
    out_nxt.restart       = head_cmd.restart;
    out_nxt.last          = is_last;
    if (head_cmd.store_valid) begin
      out_nxt.store_addr = load_base + head_cmd.offs;
      out_nxt.total_size = head_cmd.offs + {16'd0, head_cmd.store_len};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        cnt_r       <= is_last ? '0 : cnt_r + 1'b1;
      end else if (can_load) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: hdl/tftp_write_receiver.sv
// top level of the tftp write receiver: config registers, front, queue, back
//
//   channel | ports                        | moves
//   --------+------------------------------+-------------------------------
//   in      | in_valid, in_stall, in_data  | one event request per cycle unless stalled
//   out     | out_valid, out_stall, out_data | one result request per cycle unless stalled
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// the front decides each event combinationally, so a new event can be taken every
// cycle while the four-entry command queue has room; a result passes through the
// queue memory and then the output register. a flash event yields six results,
// one per cycle when not stalled, which sets the sustained rate as they pile up.
// reset is synchronous and clears state, queue and output valid.
// in_stall rises only when the command queue is full; out_stall holds the
// output register and backs up into the queue.
`timescale 1ns / 1ps

module tftp_write_receiver (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tftpw_pkg::in_t    in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tftpw_pkg::out_t   out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import tftpw_pkg::*;

  cfg_t  cfg_r;
  logic  in_fire;
  logic  push;
  cmd_t  push_cmd;
  logic  q_full;
  logic  pop;
  logic  head_valid;
  cmd_t  head_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.our_port      <= RESET_OUR_PORT;
      cfg_r.finish_opcode <= RESET_FINISH_OPC;
      cfg_r.load_base     <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OUR_PORT:   cfg_r.our_port      <= cfg_data[15:0];
        CFG_FINISH_OPC: cfg_r.finish_opcode <= cfg_data[15:0];
        CFG_LOAD_BASE:  cfg_r.load_base     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;
  assign in_fire  = in_valid && !in_stall;

  tftpw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .push     (push),
    .push_cmd (push_cmd)
  );

  tftpw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  tftpw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .load_base  (cfg_r.load_base),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
